// File: rtl/mahs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mahs_pkg
// Shared types and constants for the MPEG audio frame header sync block.
// ----------------------------------------------------------------------------
package mahs_pkg;

  typedef enum logic [1:0] {
    ST_SEARCH = 2'd0,
    ST_FOUND  = 2'd1,
    ST_LAYER1 = 2'd2,
    ST_FREE   = 2'd3
  } status_t;

  localparam logic [11:0] SYNC_MPEG    = 12'hFFF;
  localparam logic [11:0] SYNC_MPEG25  = 12'hFFE;
  localparam logic [1:0]  LAYER_RSVD   = 2'd0;
  localparam logic [1:0]  LAYER_I      = 2'd3;
  localparam logic [3:0]  BITRATE_BAD  = 4'd15;
  localparam logic [3:0]  BITRATE_FREE = 4'd0;
  localparam logic [1:0]  SFREQ_RSVD   = 2'd3;
  localparam logic [1:0]  MODE_STEREO  = 2'd0;
  localparam logic [1:0]  FILL_FULL    = 2'd3;

  // one classified byte on its way from the front to the back
  typedef struct packed {
    status_t     status;
    logic [31:0] header;   // zero unless a header was accepted
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage : mahs_pkg
`default_nettype wire

// File: rtl/mahs_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mahs_front
// Byte window, fill count and header classification; one byte per cycle while the queue is not full.
// ----------------------------------------------------------------------------
module mahs_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            in_stream_byte,
  input  wire mahs_pkg::q_status_t   q_stat,
  output logic                       push,
  output mahs_pkg::entry_t           push_entry
);
  import mahs_pkg::*;

  logic [23:0] window_r, window_nxt;
  logic [1:0]  fill_r, fill_nxt;

  logic [31:0] word;
  logic [11:0] sync;
  logic        id_bit, prot_bit, bad, accepted;
  logic [1:0]  layer, sfreq;
  logic [3:0]  bitrate;

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  assign word     = {window_r, in_stream_byte};
  assign sync     = word[31:20];
  assign id_bit   = word[19];
  assign layer    = word[18:17];
  assign prot_bit = word[16];
  assign bitrate  = word[15:12];
  assign sfreq    = word[11:10];

  assign bad = (sync != SYNC_MPEG && sync != SYNC_MPEG25) ||
               layer == LAYER_RSVD || bitrate == BITRATE_BAD || sfreq == SFREQ_RSVD ||
               (id_bit && layer == LAYER_I && prot_bit);

  assign accepted = (fill_r == FILL_FULL) && !bad;

  always_comb begin
    push_entry.header = accepted ? word : 32'd0;
    if (!accepted) begin
      push_entry.status = ST_SEARCH;
    end else if (layer == LAYER_I) begin
      push_entry.status = ST_LAYER1;  // layer I wins over free format
    end else if (bitrate == BITRATE_FREE) begin
      push_entry.status = ST_FREE;
    end else begin
      push_entry.status = ST_FOUND;
    end
  end

  always_comb begin
    window_nxt = window_r;
    fill_nxt   = fill_r;
    if (push) begin
      if (fill_r != FILL_FULL) begin
        window_nxt = word[23:0];
        fill_nxt   = fill_r + 2'd1;
      end else if (bad) begin
        window_nxt = word[23:0];  // slide by one byte
      end else begin
        window_nxt = 24'd0;
        fill_nxt   = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= 24'd0;
      fill_r   <= 2'd0;
    end else begin
      window_r <= window_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule : mahs_front
`default_nettype wire

// File: rtl/mahs_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mahs_queue
// Short FIFO of classified entries between the front and the back.
// ----------------------------------------------------------------------------
module mahs_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire mahs_pkg::entry_t  push_entry,
  input  wire logic              pop,
  output mahs_pkg::entry_t       head,
  output mahs_pkg::q_status_t    q_stat,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  import mahs_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          mem_r [DEPTH];
  logic [IW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push, do_pop;

  assign q_stat.full  = (count_r == CW'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = mem_r[rd_ptr_r];
  assign count        = count_r;

  function automatic logic [IW-1:0] ptr_inc(input logic [IW-1:0] p);
    ptr_inc = (p == IW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule : mahs_queue
`default_nettype wire

// File: rtl/mahs_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mahs_back
// Output register: splits the accepted header into its fields.
// ----------------------------------------------------------------------------
module mahs_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire mahs_pkg::entry_t      head,
  input  wire mahs_pkg::q_status_t   q_stat,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [1:0]                 out_status,
  output logic [31:0]                out_header_bits,
  output logic                       out_mpeg25,
  output logic                       out_version_id,
  output logic [1:0]                 out_layer_code,
  output logic                       out_protection,
  output logic [3:0]                 out_bitrate_code,
  output logic [1:0]                 out_rate_code,
  output logic                       out_padding,
  output logic [1:0]                 out_channel_mode,
  output logic [1:0]                 out_mode_ext
);
  import mahs_pkg::*;

  logic        valid_r;
  logic [1:0]  status_r;
  logic [31:0] header_r;
  logic        mpeg25_r;
  logic [1:0]  mode_ext_r;
  logic [31:0] h;

  assign h   = head.header;
  assign pop = !q_stat.empty && (!valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  // header is zero for searching entries, so every field reads zero then
  always_ff @(posedge clk) begin
    if (pop) begin
      status_r   <= head.status;
      header_r   <= h;
      mpeg25_r   <= (head.status != ST_SEARCH) && (h[31:20] == SYNC_MPEG25);
      mode_ext_r <= (h[7:6] == MODE_STEREO) ? 2'd0 : h[5:4];
    end
  end

  assign out_valid        = valid_r;
  assign out_status       = status_r;
  assign out_header_bits  = header_r;
  assign out_mpeg25       = mpeg25_r;
  assign out_version_id   = header_r[19];
  assign out_layer_code   = header_r[18:17];
  assign out_protection   = header_r[16];
  assign out_bitrate_code = header_r[15:12];
  assign out_rate_code    = header_r[11:10];
  assign out_padding      = header_r[9];
  assign out_channel_mode = header_r[7:6];
  assign out_mode_ext     = mode_ext_r;

endmodule : mahs_back
`default_nettype wire

// File: rtl/mpeg_audio_header_sync_top.sv
// A result is written into the queue when its byte is taken, then moves into the output register;
// an output stall can hold it in the queue. Throughput: one byte per cycle while the queue is not full;
// the window compare and push happen in the same cycle as the byte is taken. The queue (QUEUE_DEPTH entries)
// plus the output register absorb output stalls. Reset (rst_n, synchronous, active low) empties the window,
// the fill count, the queue and the output register.
`default_nettype none
// ----------------------------------------------------------------------------
// mpeg_audio_header_sync_top
// MPEG audio frame header sync: one result per stream byte.
// ----------------------------------------------------------------------------
module mpeg_audio_header_sync_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_stream_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [31:0]      out_header_bits,
  output logic             out_mpeg25,
  output logic             out_version_id,
  output logic [1:0]       out_layer_code,
  output logic             out_protection,
  output logic [3:0]       out_bitrate_code,
  output logic [1:0]       out_rate_code,
  output logic             out_padding,
  output logic [1:0]       out_channel_mode,
  output logic [1:0]       out_mode_ext
);
  import mahs_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  q_status_t       q_stat;
  entry_t          push_entry, head;
  logic            push, pop;
  logic [CW-1:0]   q_count;

  mahs_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_stream_byte (in_stream_byte),
    .q_stat         (q_stat),
    .push           (push),
    .push_entry     (push_entry)
  );

  mahs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat),
    .count      (q_count)
  );

  mahs_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .q_stat           (q_stat),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_header_bits  (out_header_bits),
    .out_mpeg25       (out_mpeg25),
    .out_version_id   (out_version_id),
    .out_layer_code   (out_layer_code),
    .out_protection   (out_protection),
    .out_bitrate_code (out_bitrate_code),
    .out_rate_code    (out_rate_code),
    .out_padding      (out_padding),
    .out_channel_mode (out_channel_mode),
    .out_mode_ext     (out_mode_ext)
  );

`ifndef SYNTHESIS
  a_search_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_SEARCH |-> out_header_bits == 32'd0)
    else $error("searching result carries header bits");

  a_found_sync: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_SEARCH |-> out_header_bits[31:21] == 11'h7FF)
    else $error("reported header without sync pattern");

  a_mode_ext: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mode_ext != 2'd0 |-> out_channel_mode != MODE_STEREO)
    else $error("mode extension set with stereo mode");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    q_count != '0 && !out_valid |=> out_valid)
    else $error("queued entry not moved to output register");
`endif

endmodule : mpeg_audio_header_sync_top
`default_nettype wire
